[design/msc_pkg.sv]
// shared types and codes for the mac subheader codec
package msc_pkg;

	localparam int CNT_W = 12;
	localparam int LEN_W = 22;
	localparam int CHAN_W = 5;
	localparam int BYTE_W = 8;
	localparam int MAX_BYTES = 4;
	localparam int IDX_W = 2;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// one subheader's worth of results, serialized one byte per transaction
	typedef struct packed {
		logic                               has;
		logic                               kind;
		logic [IDX_W-1:0]                   n_m1;
		logic [MAX_BYTES-1:0][BYTE_W-1:0]   bytes;
		logic [CHAN_W-1:0]                  chan;
		logic [LEN_W-1:0]                   len;
		logic                               fin;
		logic [CNT_W-1:0]                   cnt;
	} msc_res_t;

endpackage

[design/msc_engine.sv]
// encode and decode logic with the per-direction byte counts and decode state
module msc_engine import msc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic              op,
	input  logic [CHAN_W-1:0] chan_id,
	input  logic [LEN_W-1:0]  length,
	input  logic              last_sub,
	input  logic [BYTE_W-1:0] in_byte,
	output msc_res_t          res
);

	localparam logic [1:0] PH_ID   = 2'd0;
	localparam logic [1:0] PH_LEN1 = 2'd1;
	localparam logic [1:0] PH_LEN2 = 2'd2;
	localparam logic [1:0] PH_LEN3 = 2'd3;

	logic [1:0]        phase_q, phase_d;
	logic [CHAN_W-1:0] chan_q, chan_d;
	logic [LEN_W-1:0]  acc_q, acc_d;
	logic              fin_q, fin_d;
	logic [CNT_W-1:0]  dec_cnt_q, dec_cnt_d;
	logic [CNT_W-1:0]  enc_cnt_q, enc_cnt_d;

	logic [CNT_W:0]    enc_sum, dec_sum;
	logic [CNT_W-1:0]  enc_sat, dec_sat;
	logic [IDX_W-1:0]  enc_n_m1;
	logic              len_gt1, len_gt2;
	logic              done;

	assign len_gt1 = (length > LEN_W'(32'h7F));
	assign len_gt2 = (length > LEN_W'(32'h3FFF));
	assign enc_n_m1 = len_gt2 ? IDX_W'(3) : (len_gt1 ? IDX_W'(2) : IDX_W'(1));

	// saturating counts, bytes of this transaction included
	assign enc_sum = {1'b0, enc_cnt_q} + (CNT_W+1)'(enc_n_m1) + (CNT_W+1)'(1);
	assign enc_sat = enc_sum[CNT_W] ? COUNT_MAX : enc_sum[CNT_W-1:0];
	assign dec_sum = {1'b0, dec_cnt_q} + (CNT_W+1)'(1);
	assign dec_sat = dec_sum[CNT_W] ? COUNT_MAX : dec_sum[CNT_W-1:0];

	always_comb begin
		phase_d   = phase_q;
		chan_d    = chan_q;
		acc_d     = acc_q;
		fin_d     = fin_q;
		dec_cnt_d = dec_cnt_q;
		enc_cnt_d = enc_cnt_q;
		done      = 1'b0;
		res       = '0;
		if (op == OP_ENCODE) begin
			res.has      = 1'b1;
			res.kind     = KIND_ENC;
			res.n_m1     = enc_n_m1;
			res.bytes[0] = {2'b00, ~last_sub, chan_id};
			res.bytes[1] = {len_gt1, length[6:0]};
			res.bytes[2] = {len_gt2, length[13:7]};
			res.bytes[3] = length[21:14];
			res.cnt      = enc_sat;
			enc_cnt_d    = last_sub ? '0 : enc_sat;
		end else begin
			dec_cnt_d = dec_sat;
			unique case (phase_q)
				PH_ID: begin
					chan_d  = in_byte[CHAN_W-1:0];
					fin_d   = (in_byte[7:5] == 3'b000);
					acc_d   = '0;
					phase_d = PH_LEN1;
				end
				PH_LEN1: begin
					acc_d = LEN_W'(in_byte[6:0]);
					if (in_byte[7]) begin
						phase_d = PH_LEN2;
					end else begin
						done = 1'b1;
					end
				end
				PH_LEN2: begin
					acc_d = acc_q | {8'd0, in_byte[6:0], 7'd0};
					if (in_byte[7]) begin
						phase_d = PH_LEN3;
					end else begin
						done = 1'b1;
					end
				end
				PH_LEN3: begin
					acc_d = acc_q | {in_byte, 14'd0};
					done  = 1'b1;
				end
				default: begin
					phase_d = PH_ID;
				end
			endcase
			if (done) begin
				res.has   = 1'b1;
				res.kind  = KIND_DEC;
				res.n_m1  = '0;
				res.chan  = chan_q;
				res.len   = acc_d;
				res.fin   = fin_q;
				res.cnt   = dec_sat;
				phase_d   = PH_ID;
				dec_cnt_d = fin_q ? '0 : dec_sat;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_ID;
			chan_q    <= '0;
			acc_q     <= '0;
			fin_q     <= 1'b0;
			dec_cnt_q <= '0;
			enc_cnt_q <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			chan_q    <= chan_d;
			acc_q     <= acc_d;
			fin_q     <= fin_d;
			dec_cnt_q <= dec_cnt_d;
			enc_cnt_q <= enc_cnt_d;
		end
	end

endmodule

[design/mac_subheader_codec_top.sv]
// mac subheader codec: input register, codec engine, result register and byte serializer
// a transaction goes from the input register through the engine into the result register
// decode takes one byte per cycle while the input is not stalled; bytes that complete a
// subheader give one result; encode gives 2 to 4 results, one per cycle from the result
// register while out_stall is low, and a later result waits until its last byte is taken
// reset clears the decode state, both byte counts and all valid flags
module mac_subheader_codec_top import msc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              op,
	input  logic [CHAN_W-1:0] chan_id,
	input  logic [LEN_W-1:0]  length,
	input  logic              last_sub,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              kind,
	output logic [BYTE_W-1:0] out_byte,
	output logic [CHAN_W-1:0] dec_chan,
	output logic [LEN_W-1:0]  dec_length,
	output logic              dec_final,
	output logic [CNT_W-1:0]  header_bytes,
	output logic              last
);

	logic              valid_s1;
	logic              op_s1;
	logic [CHAN_W-1:0] chan_s1;
	logic [LEN_W-1:0]  len_s1;
	logic              fin_s1;
	logic [BYTE_W-1:0] byte_s1;

	msc_res_t          res;
	msc_res_t          res_s2;
	logic              valid_s2;
	logic [IDX_W-1:0]  idx_q;

	logic              s2_free;
	logic              adv_s1;
	logic              in_take;
	logic              out_take;
	logic              at_last;

	assign at_last  = (idx_q == res_s2.n_m1);
	assign out_take = valid_s2 && !out_stall;
	assign s2_free  = !valid_s2 || (out_take && at_last);
	assign adv_s1   = valid_s1 && (!res.has || s2_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= op;
			chan_s1 <= chan_id;
			len_s1  <= length;
			fin_s1  <= last_sub;
			byte_s1 <= in_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	msc_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (adv_s1),
		.op      (op_s1),
		.chan_id (chan_s1),
		.length  (len_s1),
		.last_sub(fin_s1),
		.in_byte (byte_s1),
		.res     (res)
	);

	always_ff @(posedge clk) begin
		if (adv_s1 && res.has) begin
			res_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (adv_s1 && res.has) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (out_take) begin
			if (at_last) begin
				valid_s2 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	assign out_valid    = valid_s2;
	assign kind         = res_s2.kind;
	assign out_byte     = res_s2.bytes[idx_q];
	assign dec_chan     = res_s2.chan;
	assign dec_length   = res_s2.len;
	assign dec_final    = res_s2.fin;
	assign header_bytes = res_s2.cnt;
	assign last         = at_last;

	// serializer index never runs past the byte count of the held subheader
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_q <= res_s2.n_m1)
		else $error("serializer index past byte count");

	// decoded subheaders are a single transaction, encoded ones at least two
	a_dec_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == KIND_DEC |-> res_s2.n_m1 == '0)
		else $error("decode result spans several transactions");

	a_enc_multi: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == KIND_ENC |-> res_s2.n_m1 != '0)
		else $error("encode result shorter than two bytes");

	// a taken result that is not the last keeps the output busy
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !at_last |=> valid_s2 && $stable(res_s2))
		else $error("result run broken before its last byte");

	// the input side only stalls with an item held
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && res.has && valid_s2)
		else $error("input stalled without a blocked item");

endmodule

[sim/tb_mac_subheader_codec_top.sv]
`timescale 1ns / 1ps
// self-checking testbench for the mac subheader codec: directed rows and random headers
module tb_mac_subheader_codec_top;
	import msc_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 355;

	typedef struct packed {
		logic              op;
		logic [CHAN_W-1:0] chan;
		logic [LEN_W-1:0]  len;
		logic              fin;
		logic [BYTE_W-1:0] byt;
	} subhdr_in_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] byt;
		logic [CHAN_W-1:0] chan;
		logic [LEN_W-1:0]  len;
		logic              fin;
		logic [CNT_W-1:0]  cnt;
		logic              lst;
	} subhdr_out_t;

	// one directed row; when typed is set the results are given here instead of predicted
	typedef struct packed {
		subhdr_in_t        stim;
		logic              typed;
		logic [2:0]        n_res;
		logic [31:0]       bytes;
		logic [CHAN_W-1:0] chan;
		logic [LEN_W-1:0]  len;
		logic              fin;
		logic [CNT_W-1:0]  cnt;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              op;
	logic [CHAN_W-1:0] chan_id;
	logic [LEN_W-1:0]  length;
	logic              last_sub;
	logic [BYTE_W-1:0] in_byte;
	logic              out_valid;
	logic              out_stall;
	logic              kind;
	logic [BYTE_W-1:0] out_byte;
	logic [CHAN_W-1:0] dec_chan;
	logic [LEN_W-1:0]  dec_length;
	logic              dec_final;
	logic [CNT_W-1:0]  header_bytes;
	logic              last;

	// predictor state
	logic [CNT_W-1:0]  enc_total = '0;
	logic [1:0]        rx_phase = '0;
	logic [CHAN_W-1:0] rx_chan = '0;
	logic [LEN_W-1:0]  rx_len = '0;
	logic              rx_fin = 1'b0;
	logic [CNT_W-1:0]  rx_total = '0;

	subhdr_out_t codec_out_q[$];
	dir_row_t dir_tab[$];
	subhdr_out_t got_res;
	subhdr_out_t want_res;
	logic [LEN_W-1:0] len_edges[6] = '{22'h0, 22'h7F, 22'h80, 22'h3FFF, 22'h4000, 22'h3FFFFF};
	int idle_pct = 33;
	int items_done = 0;
	int fail_cnt = 0;
	int cycle_cnt = 0;

	mac_subheader_codec_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.chan_id(chan_id),
		.length(length),
		.last_sub(last_sub),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.out_byte(out_byte),
		.dec_chan(dec_chan),
		.dec_length(dec_length),
		.dec_final(dec_final),
		.header_bytes(header_bytes),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] c, int n);
		int sum;
		sum = int'(c) + n;
		return (sum > int'(COUNT_MAX)) ? COUNT_MAX : sum[CNT_W-1:0];
	endfunction

	function automatic subhdr_out_t mk_res(logic k, logic [BYTE_W-1:0] b, logic [CHAN_W-1:0] ch,
			logic [LEN_W-1:0] len, logic fin, logic [CNT_W-1:0] cnt, logic lst);
		subhdr_out_t r;
		r.kind = k;
		r.byt = b;
		r.chan = ch;
		r.len = len;
		r.fin = fin;
		r.cnt = cnt;
		r.lst = lst;
		return r;
	endfunction

	// append one expected result transaction
	function automatic void exp_put(subhdr_out_t r);
		codec_out_q.insert(codec_out_q.size(), r);
	endfunction

	function automatic void add_row(dir_row_t r);
		dir_tab.insert(dir_tab.size(), r);
	endfunction

	function automatic subhdr_in_t rand_encode(int fin_pct);
		subhdr_in_t s;
		int r;
		r = $urandom_range(9);
		s.op = OP_ENCODE;
		s.chan = CHAN_W'($urandom_range(31));
		s.fin = ($urandom_range(99) < fin_pct);
		s.byt = BYTE_W'($urandom_range(255));
		if (r == 0)
			s.len = len_edges[$urandom_range(5)];
		else if (r < 4)
			s.len = LEN_W'($urandom_range(127));
		else if (r < 7)
			s.len = LEN_W'($urandom_range(16383, 128));
		else
			s.len = LEN_W'($urandom_range(22'h3FFFFF, 22'h4000));
		return s;
	endfunction

	function automatic subhdr_in_t dec_stim(logic [BYTE_W-1:0] b);
		subhdr_in_t s;
		s.op = OP_DECODE;
		s.chan = CHAN_W'($urandom_range(31));
		s.len = LEN_W'($urandom);
		s.fin = 1'($urandom_range(1));
		s.byt = b;
		return s;
	endfunction

	function automatic dir_row_t enc_row(logic typed, logic [CHAN_W-1:0] ch, logic [LEN_W-1:0] len,
			logic fin, int n, logic [31:0] bytes, int cnt);
		dir_row_t r;
		r = '0;
		r.stim.op = OP_ENCODE;
		r.stim.chan = ch;
		r.stim.len = len;
		r.stim.fin = fin;
		r.stim.byt = BYTE_W'($urandom_range(255));
		r.typed = typed;
		r.n_res = 3'(n);
		r.bytes = bytes;
		r.cnt = CNT_W'(cnt);
		return r;
	endfunction

	function automatic dir_row_t dec_row(logic typed, logic [BYTE_W-1:0] b, int n,
			logic [CHAN_W-1:0] ch, logic [LEN_W-1:0] len, logic fin, int cnt);
		dir_row_t r;
		r = '0;
		r.stim = dec_stim(b);
		r.typed = typed;
		r.n_res = 3'(n);
		r.chan = ch;
		r.len = len;
		r.fin = fin;
		r.cnt = CNT_W'(cnt);
		return r;
	endfunction

	// advance the codec state for one transaction; keep queues its results
	task automatic predict_codec(input subhdr_in_t s, input bit keep);
		logic [BYTE_W-1:0] hb [MAX_BYTES];
		int n;
		bit done;
		done = 1'b0;
		if (s.op == OP_ENCODE) begin
			n = 2;
			hb[0] = {2'b00, ~s.fin, s.chan};
			hb[1] = {1'b0, s.len[6:0]};
			hb[2] = '0;
			hb[3] = '0;
			if (s.len > 22'h7F) begin
				hb[1][7] = 1'b1;
				hb[2] = {1'b0, s.len[13:7]};
				n = 3;
				if (s.len > 22'h3FFF) begin
					hb[2][7] = 1'b1;
					hb[3] = s.len[21:14];
					n = 4;
				end
			end
			enc_total = sat_count(enc_total, n);
			if (keep)
				for (int k = 0; k < n; k++)
					exp_put(mk_res(KIND_ENC, hb[k], '0, '0, 1'b0, enc_total, k == n - 1));
			if (s.fin)
				enc_total = '0;
		end else begin
			rx_total = sat_count(rx_total, 1);
			case (rx_phase)
				2'd0: begin
					rx_chan = s.byt[4:0];
					// any of the three upper bits marks more subheaders
					rx_fin = (s.byt[7:5] == 3'b000);
					rx_len = '0;
					rx_phase = 2'd1;
				end
				2'd1: begin
					rx_len = {15'd0, s.byt[6:0]};
					if (s.byt[7])
						rx_phase = 2'd2;
					else
						done = 1'b1;
				end
				2'd2: begin
					rx_len[13:7] = s.byt[6:0];
					if (s.byt[7])
						rx_phase = 2'd3;
					else
						done = 1'b1;
				end
				default: begin
					rx_len[21:14] = s.byt;
					done = 1'b1;
				end
			endcase
			if (done) begin
				if (keep)
					exp_put(mk_res(KIND_DEC, '0, rx_chan, rx_len, rx_fin, rx_total, 1'b1));
				rx_phase = 2'd0;
				if (rx_fin)
					rx_total = '0;
			end
		end
	endtask

	// present one transaction and hold it until it is taken
	task automatic send_item(input subhdr_in_t s);
		in_valid <= 1'b1;
		op <= s.op;
		chan_id <= s.chan;
		length <= s.len;
		last_sub <= s.fin;
		in_byte <= s.byt;
		do
			@(posedge clk);
		while (in_stall);
		items_done++;
	endtask

	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic issue(input subhdr_in_t s);
		send_item(s);
		predict_codec(s, 1'b1);
		idle_gap();
	endtask

	// well-formed received subheader, with an occasional encode slipped in between octets
	task automatic send_rx_subheader(input bit fin, input int nlen);
		logic [BYTE_W-1:0] oct [MAX_BYTES];
		oct[0] = {fin ? 3'b000 : 3'($urandom_range(7, 1)), 5'($urandom_range(31))};
		oct[1] = {nlen > 1, 7'($urandom)};
		oct[2] = {nlen > 2, 7'($urandom)};
		oct[3] = 8'($urandom);
		// a broken sequence before may have left the decoder mid subheader
		while (rx_phase != 2'd0)
			issue(dec_stim(8'($urandom)));
		for (int k = 0; k <= nlen; k++) begin
			if ($urandom_range(9) == 0)
				issue(rand_encode(20));
			issue(dec_stim(oct[k]));
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt++;
		if (arst_n && out_valid && !out_stall) begin
			got_res = mk_res(kind, out_byte, dec_chan, dec_length, dec_final, header_bytes, last);
			if (codec_out_q.size() == 0) begin
				$display("%0t: result with nothing expected, got kind=%0d byte=%02h chan=%0d len=%06h fin=%0d cnt=%0d last=%0d",
					$time, got_res.kind, got_res.byt, got_res.chan, got_res.len,
					got_res.fin, got_res.cnt, got_res.lst);
				fail_cnt++;
			end else begin
				want_res = codec_out_q.pop_front();
				if (got_res !== want_res) begin
					$display("%0t: expected kind=%0d byte=%02h chan=%0d len=%06h fin=%0d cnt=%0d last=%0d",
						$time, want_res.kind, want_res.byt, want_res.chan, want_res.len,
						want_res.fin, want_res.cnt, want_res.lst);
					$display("%0t: actual   kind=%0d byte=%02h chan=%0d len=%06h fin=%0d cnt=%0d last=%0d",
						$time, got_res.kind, got_res.byt, got_res.chan, got_res.len,
						got_res.fin, got_res.cnt, got_res.lst);
					fail_cnt++;
				end
			end
		end
		out_stall <= ($urandom_range(99) < idle_pct);
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		dir_row_t row;
		int rand_start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_ENCODE;
		chan_id = '0;
		length = '0;
		last_sub = 1'b0;
		in_byte = '0;
		out_stall = 1'b0;

		// encode: each length size and its boundaries, extension bit, count restart
		add_row(enc_row(1'b1, 5'd0, 22'h0, 1'b0, 2, 32'h2000_0000, 2));
		add_row(enc_row(1'b1, 5'd31, 22'h7F, 1'b1, 2, 32'h1F7F_0000, 4));
		add_row(enc_row(1'b1, 5'd5, 22'h80, 1'b0, 3, 32'h2580_0100, 3));
		add_row(enc_row(1'b1, 5'd10, 22'h3FFF, 1'b0, 3, 32'h2AFF_7F00, 6));
		add_row(enc_row(1'b1, 5'd1, 22'h4000, 1'b0, 4, 32'h2180_8001, 10));
		add_row(enc_row(1'b1, 5'd31, 22'h3FFFFF, 1'b1, 4, 32'h1FFF_FFFF, 14));
		add_row(enc_row(1'b0, 5'd17, 22'h12345, 1'b1, 0, '0, 0));
		// decode: short, medium and long lengths, odd extension patterns
		add_row(dec_row(1'b1, 8'h3F, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'h05, 1, 5'd31, 22'h5, 1'b0, 2));
		add_row(dec_row(1'b1, 8'h40, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'hFF, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'h7F, 1, 5'd0, 22'h3FFF, 1'b0, 5));
		add_row(dec_row(1'b1, 8'h80, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'h80, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'h80, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'hFF, 1, 5'd0, 22'h3FC000, 1'b0, 9));
		add_row(dec_row(1'b1, 8'h1F, 0, '0, '0, 1'b0, 0));
		// encode in the middle of a decode must leave it alone
		add_row(enc_row(1'b1, 5'd0, 22'h0, 1'b1, 2, 32'h0000_0000, 2));
		add_row(dec_row(1'b1, 8'hFF, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'hFF, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'hFF, 1, 5'd31, 22'h3FFFFF, 1'b1, 13));
		add_row(dec_row(1'b1, 8'hE0, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b0, 8'h2A, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'h00, 0, '0, '0, 1'b0, 0));
		add_row(dec_row(1'b1, 8'h00, 1, 5'd0, 22'h0, 1'b1, 4));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			send_item(row.stim);
			predict_codec(row.stim, !row.typed);
			if (row.typed)
				for (int k = 0; k < row.n_res; k++)
					if (row.stim.op == OP_ENCODE)
						exp_put(mk_res(KIND_ENC, row.bytes[31 - 8 * k -: 8], '0,
							'0, 1'b0, row.cnt, k == row.n_res - 1));
					else
						exp_put(mk_res(KIND_DEC, '0, row.chan, row.len, row.fin,
							row.cnt, 1'b1));
			idle_gap();
		end

		// random mix: mostly whole subheaders, some stray decode bytes
		rand_start = items_done;
		while (items_done < rand_start + RANDOM_ITEMS) begin
			if (items_done >= rand_start + 120 && items_done < rand_start + 240)
				idle_pct = 0;
			else
				idle_pct = 33;
			case ($urandom_range(9))
				0, 1, 2, 3: issue(rand_encode(20));
				9: issue(dec_stim(8'($urandom)));
				default: send_rx_subheader($urandom_range(99) < 20, $urandom_range(1, 3));
			endcase
		end
		idle_pct = 33;

		in_valid <= 1'b0;
		while (codec_out_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
